// ===== src/lppd_pkg.sv =====
// Shared constants and types for the length-prefixed packet deframer.
package lppd_pkg;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_MARKER = 2'd1,
        ERR_LENGTH = 2'd2
    } err_code_t;

    localparam logic [15:0] MIN_FRAME_LENGTH = 16'd4;
    localparam logic [7:0]  MARKER_RESET     = 8'hFF;

    localparam logic [15:0] POS_MARKER   = 16'd0;
    localparam logic [15:0] POS_ID       = 16'd1;
    localparam logic [15:0] POS_LEN_LOW  = 16'd2;
    localparam logic [15:0] POS_LEN_HIGH = 16'd3;
    localparam logic [15:0] POS_PAYLOAD  = 16'd4;

endpackage

// ===== src/length_prefixed_packet_deframer_unit.sv =====
// Top level of the length-prefixed packet deframer: input stage, frame tracking, result stage.
// A word is registered in the input stage, its result in the result stage. Throughput: one word
// per cycle unless a word with a result meets a stalled result stage; the position counter and its
// length compare sit between the input and result registers; words without a result leave even
// while a result waits. Reset: rst_n is asynchronous and active low; it empties both stages,
// clears the frame state and sets the header marker to 0xFF.
module length_prefixed_packet_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        flush,
    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [15:0] position,
    output logic        frame_end,
    output logic [1:0]  error_code,
    // Configuration: header marker register.
    input  logic        header_marker_we,
    input  logic [7:0]  header_marker_wdata
);

    // Configuration register.
    logic [7:0] header_marker_reg;

    // Input word stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       flush_reg;

    // Frame tracking state.
    logic [15:0] byte_position_reg, byte_position_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic        error_latched_reg, error_latched_next;

    // Result stage.
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [15:0] position_reg;
    logic        frame_end_reg;
    logic [1:0]  error_code_reg;

    // Result computed from the word in the input stage.
    logic        has_result;
    logic [7:0]  res_byte;
    logic        res_end;
    logic [1:0]  res_err;
    logic        advance;
    logic [15:0] len_word;
    logic [16:0] pos_inc;

    // The input stage moves on when it holds a word and either that word gives no result
    // or the result register is free or being emptied in this cycle.
    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign len_word = {in_byte_reg, length_low_reg};
    assign pos_inc  = {1'b0, byte_position_reg} + 17'd1;

    // Frame tracking: next state and the result for the staged word.
    always_comb
    begin
        byte_position_next = byte_position_reg;
        length_low_next    = length_low_reg;
        frame_length_next  = frame_length_reg;
        error_latched_next = error_latched_reg;
        has_result         = 1'b0;
        res_byte           = in_byte_reg;
        res_end            = 1'b0;
        res_err            = lppd_pkg::ERR_NONE;

        if (flush_reg)
        begin
            // A flush returns the frame state to reset and gives no result.
            byte_position_next = '0;
            length_low_next    = '0;
            frame_length_next  = '0;
            error_latched_next = 1'b0;
        end
        else if (!error_latched_reg)
        begin
            has_result = 1'b1;
            case (byte_position_reg)
                lppd_pkg::POS_MARKER:
                begin
                    if (in_byte_reg != header_marker_reg)
                    begin
                        error_latched_next = 1'b1;
                        res_byte           = '0;
                        res_err            = lppd_pkg::ERR_MARKER;
                    end
                    else
                    begin
                        byte_position_next = lppd_pkg::POS_ID;
                    end
                end
                lppd_pkg::POS_ID:
                begin
                    byte_position_next = lppd_pkg::POS_LEN_LOW;
                end
                lppd_pkg::POS_LEN_LOW:
                begin
                    length_low_next    = in_byte_reg;
                    byte_position_next = lppd_pkg::POS_LEN_HIGH;
                end
                lppd_pkg::POS_LEN_HIGH:
                begin
                    if (len_word < lppd_pkg::MIN_FRAME_LENGTH)
                    begin
                        // The error result takes the place of the length high word.
                        error_latched_next = 1'b1;
                        res_byte           = '0;
                        res_err            = lppd_pkg::ERR_LENGTH;
                    end
                    else
                    begin
                        frame_length_next = len_word;
                        if (len_word == lppd_pkg::MIN_FRAME_LENGTH)
                        begin
                            // A header-only frame ends on its length high word.
                            byte_position_next = lppd_pkg::POS_MARKER;
                            res_end            = 1'b1;
                        end
                        else
                        begin
                            byte_position_next = lppd_pkg::POS_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    // Payload word: the frame ends when the next index reaches the length.
                    if (pos_inc >= {1'b0, frame_length_reg})
                    begin
                        byte_position_next = lppd_pkg::POS_MARKER;
                        res_end            = 1'b1;
                    end
                    else
                    begin
                        byte_position_next = pos_inc[15:0];
                    end
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_marker_reg <= lppd_pkg::MARKER_RESET;
        end
        else if (header_marker_we)
        begin
            header_marker_reg <= header_marker_wdata;
        end
    end

    // Input word stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input word stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            flush_reg   <= flush;
        end
    end

    // Frame state, updated once for each word that leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            length_low_reg    <= '0;
            frame_length_reg  <= '0;
            error_latched_reg <= 1'b0;
        end
        else if (advance)
        begin
            byte_position_reg <= byte_position_next;
            length_low_reg    <= length_low_next;
            frame_length_reg  <= frame_length_next;
            error_latched_reg <= error_latched_next;
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_byte_reg   <= res_byte;
            position_reg   <= byte_position_reg;
            frame_end_reg  <= res_end;
            error_code_reg <= res_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign position   = position_reg;
    assign frame_end  = frame_end_reg;
    assign error_code = error_code_reg;

    // A dropped word after an error never produces a result.
    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && error_latched_reg && !flush_reg) |-> !has_result)
        else $error("result produced while dropping after an error");

    // In the payload the position always stays below the frame length.
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_position_reg >= lppd_pkg::POS_PAYLOAD) |-> (byte_position_reg < frame_length_reg))
        else $error("payload position beyond frame length");

    // Error results carry a zero byte and no frame end mark.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != lppd_pkg::ERR_NONE) |-> (out_byte == 8'd0 && !frame_end))
        else $error("malformed error result");

    // A word held in the input stage that cannot move on is still there next cycle.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage word lost");

    // An error result latches the error state.
    a_err_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result && res_err != lppd_pkg::ERR_NONE) |=> error_latched_reg)
        else $error("error not latched");

endmodule
